// ----- src/kih_pkg.sv -----
// Package for the keyed index with hit tracking.
// Operation codes, command and result types shared by all modules.
package kih_pkg;

    localparam int KEY_W  = 64;
    localparam int ADDR_W = 32;
    localparam int HINT_W = 16;
    localparam int CNT_W  = 32;
    localparam logic [7:0] HIST_TOP = 8'h80;

    typedef enum logic [2:0] {
        OP_LOOKUP  = 3'd0,
        OP_PEEK    = 3'd1,
        OP_INSERT  = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_REM_IF  = 3'd4,
        OP_REPL_IF = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_WAIT,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        kind;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] address;
        logic [HINT_W-1:0] size_hint;
        logic [ADDR_W-1:0] old_address;
    } t_cmd;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] rec_address;
        logic [HINT_W-1:0] rec_size_hint;
        logic [7:0]        rec_current_hits;
        logic [7:0]        rec_extra;
        logic              matched;
        logic              tracked_removal;
        logic [7:0]        removed_hits_estimate;
        logic              table_full;
        logic [CNT_W-1:0]  unaccessed_count;
    } t_res;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) n = n + {3'd0, v[i]};
        return n;
    endfunction

endpackage

// ----- src/kih_if.sv -----
// Valid/ready channel interfaces for commands and results.
// Depends on kih_pkg.
interface kih_cmd_if;
    logic            valid;
    logic            ready;
    kih_pkg::t_cmd   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface kih_res_if;
    logic            valid;
    logic            ready;
    kih_pkg::t_res   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/kih_front.sv -----
// Front end: accepts commands and queues them in a two-entry FIFO.
// Depends on kih_pkg and kih_if.
module kih_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kih_cmd_if.sink           s_in,
    output logic              o_q_valid,
    output kih_pkg::t_cmd     o_q_cmd,
    input  logic              i_q_pop
);
    import kih_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign s_in.ready = (r_cnt != 2'd2);
    assign push       = s_in.valid && s_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= s_in.payload;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ----- src/kih_back.sv -----
// Back end: scans the record memory one entry a cycle and writes back.
// Depends on kih_pkg and kih_if.
module kih_back #(
    parameter int ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_extra_mode,
    input  logic              i_q_valid,
    input  kih_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    kih_res_if.source         m_out
);
    import kih_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = KEY_W + ADDR_W + HINT_W + 16;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
        logic [HINT_W-1:0] hint;
        logic [7:0]        cur;
        logic [7:0]        extra;
    } t_rec;

    logic [RW-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [IW:0] r_idx;
    logic [IW-1:0] r_hit, r_free;
    logic   r_found, r_has_free, r_rd_v;
    logic [IW-1:0] r_rd_idx;
    t_rec   r_rd, r_hrec;
    t_res   r_res;
    logic   r_out_v;
    logic [CNT_W-1:0] r_cnt;

    logic   done_scan, wr_en, set_v, clr_v;
    logic [IW-1:0] wr_idx;
    t_rec   wr_rec;
    t_res   res;
    logic [CNT_W-1:0] n_cnt;
    logic [3:0] p;
    logic [7:0] est;
    logic   addr_m, tracked;

    assign done_scan = (r_idx == (IW+1)'(ENTRIES));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_q_valid && !r_out_v)
                          n_state = (i_q_cmd.kind == OP_CLEAR ||
                                     i_q_cmd.kind == OP_NONE) ? ST_CLEAR : ST_SCAN;
            ST_CLEAR: n_state = ST_IDLE;
            ST_SCAN:  if (done_scan) n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_state == ST_IDLE) && i_q_valid && !r_out_v;
    end

    always_comb begin
        p      = pop8(r_hrec.extra);
        est    = !i_extra_mode ? r_hrec.extra :
                 ((p > r_hrec.cur[3:0] && r_hrec.cur < 8'd8) ? {4'd0, p} : r_hrec.cur);
        res    = '0;
        wr_en  = 1'b0;
        set_v  = 1'b0;
        clr_v  = 1'b0;
        wr_idx = r_hit;
        wr_rec = r_hrec;
        tracked = 1'b0;
        if (r_found) begin
            res.found            = 1'b1;
            res.rec_address      = r_hrec.addr;
            res.rec_size_hint    = r_hrec.hint;
            res.rec_current_hits = r_hrec.cur;
            res.rec_extra        = r_hrec.extra;
        end
        addr_m = 1'b0;
        case (r_cmd.kind)
            OP_LOOKUP: if (r_found) begin
                wr_en = 1'b1;
                wr_rec.cur = sat_inc8(r_hrec.cur);
                if (!i_extra_mode) wr_rec.extra = sat_inc8(r_hrec.extra);
            end
            OP_INSERT: begin
                wr_rec.addr  = r_cmd.address;
                wr_rec.hint  = r_cmd.size_hint;
                wr_rec.cur   = '0;
                wr_rec.extra = '0;
                wr_rec.key   = r_cmd.key;
                if (r_found) begin
                    wr_en = 1'b1;
                    tracked = 1'b1;
                end else if (r_has_free) begin
                    wr_en = 1'b1;
                    set_v = 1'b1;
                    wr_idx = r_free;
                end else res.table_full = 1'b1;
            end
            OP_REMOVE: if (r_found) begin
                tracked = 1'b1;
                clr_v = 1'b1;
            end
            OP_REM_IF: if (r_found && r_hrec.addr == r_cmd.address) begin
                addr_m = 1'b1;
                tracked = 1'b1;
                clr_v = 1'b1;
            end
            OP_REPL_IF: if (r_found && r_hrec.addr == r_cmd.old_address) begin
                addr_m = 1'b1;
                wr_en = 1'b1;
                wr_rec.addr = r_cmd.address;
                wr_rec.cur = '0;
                if (i_extra_mode)
                    wr_rec.extra = (r_hrec.extra >> 1) |
                                   ((r_hrec.cur != 8'd0) ? HIST_TOP : 8'd0);
            end
            default: ;
        endcase
        res.matched = addr_m;
        res.tracked_removal = tracked;
        res.removed_hits_estimate = tracked ? est : 8'd0;
        n_cnt = r_cnt;
        if (tracked && est == 8'd0 && r_cnt != '1) n_cnt = r_cnt + 1'b1;
        if (r_cmd.kind == OP_CLEAR) n_cnt = '0;
        res.unaccessed_count = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        r_rd_v   <= (r_state == ST_SCAN) && !done_scan;
        r_rd_idx <= r_idx[IW-1:0];
        if (r_state == ST_SCAN && !done_scan) r_rd <= t_rec'(mem[r_idx[IW-1:0]]);
        if (r_state == ST_WRITE && wr_en) mem[wr_idx] <= RW'(wr_rec);
        if (o_q_pop) r_cmd <= i_q_cmd;
        if (r_rd_v && !r_found && r_valid[r_rd_idx] && r_rd.key == r_cmd.key) begin
            r_hrec <= r_rd;
            r_hit  <= r_rd_idx;
        end
        if (r_state == ST_SCAN && !done_scan && !r_has_free && !r_valid[r_idx[IW-1:0]])
            r_free <= r_idx[IW-1:0];
        if (r_state == ST_WRITE || r_state == ST_CLEAR) r_res <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
            r_out_v    <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;
            if (m_out.valid && m_out.ready) r_out_v <= 1'b0;
            if (o_q_pop) begin
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_has_free <= 1'b0;
            end
            if (r_state == ST_SCAN && !done_scan) begin
                r_idx <= r_idx + 1'b1;
                if (!r_valid[r_idx[IW-1:0]]) r_has_free <= 1'b1;
            end
            if (r_rd_v && r_valid[r_rd_idx] && r_rd.key == r_cmd.key) r_found <= 1'b1;
            if (r_state == ST_CLEAR) begin
                r_out_v <= 1'b1;
                r_cnt   <= n_cnt;
                if (r_cmd.kind == OP_CLEAR) r_valid <= '0;
            end
            if (r_state == ST_WRITE) begin
                r_out_v <= 1'b1;
                r_cnt   <= n_cnt;
                if (set_v) r_valid[wr_idx] <= 1'b1;
                if (clr_v) r_valid[wr_idx] <= 1'b0;
            end
        end
    end

    assign m_out.valid   = r_out_v;
    assign m_out.payload = r_res;
endmodule

// ----- src/keyed_index_with_hit_tracking_top.sv -----
// Top level of the keyed index with hit tracking.
// Depends on kih_pkg, kih_if, kih_front and kih_back.
//
//  channel  dir  handshake        payload
//  s_in     in   valid/ready      kind, key, address, size_hint, old_address
//  m_out    out  valid/ready      found .. unaccessed_count
//  cfg      in   i_cfg_we         extra_mode (bit 0 of i_cfg_wdata)
//
// A search or update reads all entries, one memory read a cycle, then passes
// the ST_WAIT state and writes back in ST_WRITE. Clear-all uses ST_CLEAR.
// Reset is synchronous and needs no clearing pass; valid bits clear at once.
// The front FIFO keeps accepting, until its two entries are full, while a result waits on a stalled output.
module keyed_index_with_hit_tracking_top #(
    parameter int ENTRIES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    kih_cmd_if.sink   s_in,
    kih_res_if.source m_out
);
    import kih_pkg::*;

    logic r_mode;
    logic q_valid, q_pop;
    t_cmd q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b0;
        else if (i_cfg_we) r_mode <= i_cfg_wdata;
    end

    kih_front u_front (
        .i_clk, .i_rst_n, .s_in,
        .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop)
    );

    kih_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_extra_mode(r_mode),
        .i_q_valid(q_valid), .i_q_cmd(q_cmd), .o_q_pop(q_pop), .m_out
    );

`ifndef SYNTHESIS
    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid) else $error("result dropped");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !(m_out.payload.table_full && m_out.payload.found))
        else $error("full with found");
`endif
endmodule
